// ===== rtl/countdown_task_dispatcher_defines.svh =====
// assertion macros
`ifndef COUNTDOWN_TASK_DISPATCHER_DEFINES_SVH
`define COUNTDOWN_TASK_DISPATCHER_DEFINES_SVH

`define CTD_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("ctd assertion failed");

`define CTD_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("ctd assertion failed");

`endif

// ===== rtl/ctd_pkg.sv =====
package ctd_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TICK   = 2'd2,
    OP_RUN    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FIN,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic scan;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic op_run;
    logic scan_last;
  } dp_status_t;

  localparam logic [31:0] CD_SAT_MIN = 32'h8000_0000;
  localparam int          COUNT_MAX  = 31;

endpackage

// ===== rtl/ctd_ctrl.sv =====
module ctd_ctrl
  import ctd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output ctl_cmd_t   cmd,
  output logic       busy,
  output logic       done
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    done       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = status.op_run ? ST_SCAN : ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_RESP;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_next = ST_RESP;
      end
      ST_RESP: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

// ===== rtl/ctd_datapath.sv =====
module ctd_datapath
  import ctd_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  ctl_cmd_t    cmd,
  output dp_status_t  status,
  input  logic [1:0]  operation,
  input  logic [3:0]  slot,
  input  logic        repeat_mode,
  input  logic [30:0] period,
  input  logic [7:0]  handler_tag,
  output logic        ok,
  output logic        dispatched,
  output logic [3:0]  dispatch_slot,
  output logic [7:0]  dispatch_tag,
  output logic [31:0] tick_count,
  output logic [4:0]  active_count
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  op_t          op_q;
  logic [IW-1:0] slot_q;
  logic         slot_ok;
  logic         rep_q;
  logic [30:0]  per_q;
  logic [7:0]   tag_q;

  logic [SLOTS-1:0] active;
  logic [31:0]      cd    [SLOTS];
  logic [30:0]      per   [SLOTS];
  logic             rep   [SLOTS];
  logic [7:0]       tag   [SLOTS];
  logic [IW-1:0]    rank  [SLOTS];
  logic [CW-1:0]    cnt;
  logic [31:0]      ticks;

  logic [IW-1:0] scan_idx;
  logic          found;
  logic [IW-1:0] best_idx;
  logic [31:0]   best_cd;
  logic [IW-1:0] best_rank;
  logic [30:0]   best_per;
  logic          best_rep;
  logic [7:0]    best_tag;

  logic [IW-1:0] rd_idx;
  logic [IW-1:0] rank_rd;
  logic          act_rd;
  logic          better;
  logic          due;

  assign rd_idx  = cmd.scan ? scan_idx : slot_q;
  assign rank_rd = rank[rd_idx];
  assign act_rd  = active[rd_idx];
  assign better  = !found || ($signed(cd[rd_idx]) < $signed(best_cd)) ||
                   ((cd[rd_idx] == best_cd) && (rank_rd < best_rank));
  assign due     = ($signed(best_cd) <= 0);

  assign status.op_run    = (operation == OP_RUN);
  assign status.scan_last = (scan_idx == IW'(SLOTS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      cnt    <= '0;
      ticks  <= '0;
    end else begin
      if (cmd.exec) begin
        case (op_q)
          OP_ADD: begin
            if (slot_ok && per_q != '0) begin
              for (int i = 0; i < SLOTS; i++) begin
                if (act_rd && active[i] && IW'(i) != slot_q && rank[i] > rank_rd) begin
                  rank[i] <= rank[i] - 1'b1;
                end
              end
              rank[slot_q]   <= IW'(cnt - CW'(act_rd));
              active[slot_q] <= 1'b1;
              per[slot_q]    <= per_q;
              cd[slot_q]     <= {1'b0, per_q};
              rep[slot_q]    <= rep_q;
              tag[slot_q]    <= tag_q;
              cnt            <= cnt + CW'(!act_rd);
            end
          end
          OP_REMOVE: begin
            if (slot_ok && act_rd) begin
              for (int i = 0; i < SLOTS; i++) begin
                if (active[i] && IW'(i) != slot_q && rank[i] > rank_rd) begin
                  rank[i] <= rank[i] - 1'b1;
                end
              end
              active[slot_q] <= 1'b0;
              cnt            <= cnt - 1'b1;
            end
          end
          OP_TICK: begin
            for (int i = 0; i < SLOTS; i++) begin
              if (active[i] && cd[i] != CD_SAT_MIN) begin
                cd[i] <= cd[i] - 1'b1;
              end
            end
            ticks <= ticks + 1'b1;
          end
          default: begin
          end
        endcase
      end
      if (cmd.finish && found) begin
        if (due && !best_rep) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (active[i] && IW'(i) != best_idx && rank[i] > best_rank) begin
              rank[i] <= rank[i] - 1'b1;
            end
          end
          active[best_idx] <= 1'b0;
          cnt              <= cnt - 1'b1;
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (active[i] && rank[i] < best_rank) begin
              rank[i] <= rank[i] + 1'b1;
            end
          end
          rank[best_idx] <= '0;
          if (due) begin
            cd[best_idx] <= {1'b0, best_per};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q     <= op_t'(operation);
      slot_q   <= IW'(slot);
      slot_ok  <= (int'(slot) < SLOTS);
      rep_q    <= repeat_mode;
      per_q    <= period;
      tag_q    <= handler_tag;
      scan_idx <= '0;
      found    <= 1'b0;
    end
    if (cmd.scan) begin
      scan_idx <= scan_idx + 1'b1;
      if (act_rd && better) begin
        found     <= 1'b1;
        best_idx  <= scan_idx;
        best_cd   <= cd[rd_idx];
        best_rank <= rank_rd;
        best_per  <= per[rd_idx];
        best_rep  <= rep[rd_idx];
        best_tag  <= tag[rd_idx];
      end
    end
    if (cmd.exec) begin
      ok            <= (op_q == OP_TICK) || (slot_ok && (op_q == OP_REMOVE || per_q != '0));
      dispatched    <= 1'b0;
      dispatch_slot <= '0;
      dispatch_tag  <= '0;
    end
    if (cmd.finish) begin
      ok            <= 1'b1;
      dispatched    <= found && due;
      dispatch_slot <= (found && due) ? 4'(best_idx) : 4'd0;
      dispatch_tag  <= (found && due) ? best_tag : 8'd0;
    end
  end

  assign tick_count   = ticks;
  assign active_count = (int'(cnt) > COUNT_MAX) ? 5'(COUNT_MAX) : 5'(cnt);

endmodule

// ===== rtl/countdown_task_dispatcher.sv =====
// Countdown task dispatcher: a table of SLOTS timer task slots.
// Input: pulse start with operation, slot, repeat_mode, period and
// handler_tag while busy is low; the item is taken at that edge.
// Operations: add, remove, tick (decrement all active countdowns),
// run (pick the active task with the smallest countdown and dispatch it if due).
// Output: done is high for one cycle with ok, dispatched,
// dispatch_slot, dispatch_tag, tick_count and active_count valid.
// The receiver cannot stall; results must be taken when done is high.
// Sequence: add, remove and tick pass through the exec and response
// states; run scans one slot per cycle through a single read
// mux, then passes through the finish and response states.
// The block takes no new item while one is in flight;
// busy stays high until done has been shown.
// Reset (rst, synchronous): all slots inactive, tick count zero,
// block idle. No clearing pass is needed.
module countdown_task_dispatcher
  import ctd_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic [1:0]  operation,
  input  logic [3:0]  slot,
  input  logic        repeat_mode,
  input  logic [30:0] period,
  input  logic [7:0]  handler_tag,
  output logic        ok,
  output logic        dispatched,
  output logic [3:0]  dispatch_slot,
  output logic [7:0]  dispatch_tag,
  output logic [31:0] tick_count,
  output logic [4:0]  active_count
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  ctd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  ctd_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .operation     (operation),
    .slot          (slot),
    .repeat_mode   (repeat_mode),
    .period        (period),
    .handler_tag   (handler_tag),
    .ok            (ok),
    .dispatched    (dispatched),
    .dispatch_slot (dispatch_slot),
    .dispatch_tag  (dispatch_tag),
    .tick_count    (tick_count),
    .active_count  (active_count)
  );

endmodule

// ===== rtl/ctd_checker.sv =====
`include "countdown_task_dispatcher_defines.svh"

module ctd_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        ok,
  input logic        dispatched,
  input logic [31:0] tick_count
);

  `CTD_ASSERT_NXT(a_start_busy, start && !busy, busy)
  `CTD_ASSERT_IMP(a_done_busy, done, busy)
  `CTD_ASSERT_NXT(a_done_pulse, done, !done && !busy)
  `CTD_ASSERT_IMP(a_disp_ok, done && dispatched, ok)
  `CTD_ASSERT_NXT(a_ticks_idle, !busy && !start, $stable(tick_count))

endmodule

bind countdown_task_dispatcher ctd_checker u_ctd_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .ok         (ok),
  .dispatched (dispatched),
  .tick_count (tick_count)
);
